// File: sv/lpg_pkg.sv
// ---------------------------------------------------------------------------
// lpg_pkg: shared types and constants of the line pixel generator
// Segment and pixel payloads, the classified line descriptor and the
// sizing of the descriptor queue.
// ---------------------------------------------------------------------------
package lpg_pkg;

	localparam int COORD_BITS  = 6;
	localparam int COLOUR_BITS = 24;

	// Descriptor queue sizing (depth is a power of two so pointers wrap)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]  coord_t;
	typedef logic [COORD_BITS:0]    err_t;
	typedef logic [COLOUR_BITS-1:0] colour_t;

	// One input transfer: a line segment
	typedef struct packed {
		coord_t  start_x;
		coord_t  start_y;
		coord_t  end_x;
		coord_t  end_y;
		colour_t colour;
	} segment_t;

	// One output transfer: a pixel
	typedef struct packed {
		coord_t  pixel_x;
		coord_t  pixel_y;
		colour_t pixel_colour;
		logic    last_pixel;
	} pixel_t;

	// Classified line, ready for stepping
	typedef struct packed {
		coord_t  start_x;
		coord_t  start_y;
		coord_t  major_delta;
		coord_t  minor_delta;
		logic    x_negative;
		logic    y_negative;
		logic    x_major;
		colour_t colour;
	} line_desc_t;

	// Queue to stepper handshake
	typedef struct packed {
		logic       valid;
		line_desc_t desc;
	} desc_flow_t;

	// Stepper status seen by the top level
	typedef struct packed {
		logic active;
		logic pop;
	} back_status_t;

endpackage

// File: sv/lpg_front.sv
// ---------------------------------------------------------------------------
// lpg_front: segment classifier
// Computes absolute deltas, step directions and the major axis of an
// incoming segment and forms the line descriptor.
// ---------------------------------------------------------------------------
module lpg_front (
	input  lpg_pkg::segment_t   seg,
	output lpg_pkg::line_desc_t desc
);

	logic           x_pos;
	logic           y_pos;
	lpg_pkg::coord_t adx;
	lpg_pkg::coord_t ady;
	logic           x_major;

	// Compare endpoints and take absolute deltas
	always_comb begin
		x_pos   = seg.end_x > seg.start_x;
		y_pos   = seg.end_y > seg.start_y;
		adx     = x_pos ? seg.end_x - seg.start_x : seg.start_x - seg.end_x;
		ady     = y_pos ? seg.end_y - seg.start_y : seg.start_y - seg.end_y;
		x_major = adx > ady;
	end

	// Build the descriptor; a zero delta counts as a negative direction
	always_comb begin
		desc.start_x     = seg.start_x;
		desc.start_y     = seg.start_y;
		desc.major_delta = x_major ? adx : ady;
		desc.minor_delta = x_major ? ady : adx;
		desc.x_negative  = ~x_pos;
		desc.y_negative  = ~y_pos;
		desc.x_major     = x_major;
		desc.colour      = seg.colour;
	end

endmodule

// File: sv/lpg_queue.sv
// ---------------------------------------------------------------------------
// lpg_queue: line descriptor queue
// Short FIFO that decouples the classifier from the pixel stepper.
// ---------------------------------------------------------------------------
module lpg_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lpg_pkg::line_desc_t  wr_desc,
	output logic                 full,
	input  logic                 pop,
	output lpg_pkg::desc_flow_t  rd,
	output logic [lpg_pkg::QCNT_W-1:0] count
);

	lpg_pkg::line_desc_t             mem_q [lpg_pkg::QUEUE_DEPTH];
	logic [lpg_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lpg_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lpg_pkg::QCNT_W-1:0]      count_q;

	assign full     = count_q == lpg_pkg::QCNT_W'(lpg_pkg::QUEUE_DEPTH);
	assign rd.valid = count_q != '0;
	assign rd.desc  = mem_q[rd_ptr_q];
	assign count    = count_q;

	// Store pushed descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/lpg_back.sv
// ---------------------------------------------------------------------------
// lpg_back: pixel stepper
// Walks one line descriptor at a time with the Bresenham error term and
// emits one pixel per cycle into an output register while pix_ready does not stall it.
// ---------------------------------------------------------------------------
module lpg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpg_pkg::desc_flow_t   rd,
	output lpg_pkg::back_status_t status,
	output logic                  pix_valid,
	input  logic                  pix_ready,
	output lpg_pkg::pixel_t       pix
);

	logic            active_q;
	lpg_pkg::coord_t cur_x_q;
	lpg_pkg::coord_t cur_y_q;
	lpg_pkg::err_t   err_q;
	lpg_pkg::coord_t steps_q;
	lpg_pkg::coord_t major_q;
	lpg_pkg::coord_t minor_q;
	logic            x_neg_q;
	logic            y_neg_q;
	logic            x_major_q;
	lpg_pkg::colour_t colour_q;

	logic            pix_valid_q;
	lpg_pkg::pixel_t pix_q;

	logic            emit;
	logic            last;
	logic            pop;
	lpg_pkg::err_t   err_sum;
	logic            minor_step;
	lpg_pkg::err_t   err_next;
	lpg_pkg::coord_t x_next;
	lpg_pkg::coord_t y_next;
	logic            step_x;
	logic            step_y;

	// Emit when a line is live and the output register is free or draining
	assign emit = active_q && (!pix_valid_q || pix_ready);
	assign last = steps_q == '0;
	assign pop  = rd.valid && (!active_q || (emit && last));

	// Error update and coordinate steps for the next pixel
	always_comb begin
		err_sum    = err_q + lpg_pkg::err_t'(minor_q);
		minor_step = err_sum >= lpg_pkg::err_t'(major_q);
		err_next   = minor_step ? err_sum - lpg_pkg::err_t'(major_q) : err_sum;
		step_x     = x_major_q || minor_step;
		step_y     = !x_major_q || minor_step;
		x_next     = cur_x_q;
		y_next     = cur_y_q;
		if (step_x) begin
			x_next = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (step_y) begin
			y_next = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	// Control: load a new line, finish on its last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
		end else if (emit && last) begin
			active_q <= 1'b0;
		end
	end

	// Line state: load from the queue or advance one step
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_x_q   <= rd.desc.start_x;
			cur_y_q   <= rd.desc.start_y;
			err_q     <= lpg_pkg::err_t'(rd.desc.major_delta >> 1);
			steps_q   <= rd.desc.major_delta;
			major_q   <= rd.desc.major_delta;
			minor_q   <= rd.desc.minor_delta;
			x_neg_q   <= rd.desc.x_negative;
			y_neg_q   <= rd.desc.y_negative;
			x_major_q <= rd.desc.x_major;
			colour_q  <= rd.desc.colour;
		end else if (emit && !last) begin
			cur_x_q <= x_next;
			cur_y_q <= y_next;
			err_q   <= err_next;
			steps_q <= steps_q - 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (emit) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q.pixel_x      <= cur_x_q;
			pix_q.pixel_y      <= cur_y_q;
			pix_q.pixel_colour <= colour_q;
			pix_q.last_pixel   <= last;
		end
	end

	assign pix_valid     = pix_valid_q;
	assign pix           = pix_q;
	assign status.active = active_q;
	assign status.pop    = pop;

endmodule

// File: sv/line_pixel_generator_top.sv
// ---------------------------------------------------------------------------
// line_pixel_generator_top: Bresenham line pixel generator
// Takes line segments and emits every pixel of each line in drawing order,
// flagging the final pixel.
// ---------------------------------------------------------------------------
//  channel   signals                          payload
//  segment   seg_valid / seg_ready / seg      start_x, start_y, end_x, end_y, colour
//  pixel     pix_valid / pix_ready / pix      pixel_x, pixel_y, pixel_colour, last_pixel
//
//  A line of major delta D gives D+1 pixels (1 to 64 here) at one pixel per
//  cycle from the stepper while pix_ready does not stall it; after the stepper
//  has been idle, the first line is loaded from the queue before its first pixel.
//  Segments are classified on entry and held in a two-entry queue; seg_ready
//  is low only while that queue is full.
//  A stalled pix_ready holds the output register and the stepper.
//  Reset is asynchronous and clears queue, stepper and output valid.
// ---------------------------------------------------------------------------
module line_pixel_generator_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seg_valid,
	output logic              seg_ready,
	input  lpg_pkg::segment_t seg,
	output logic              pix_valid,
	input  logic              pix_ready,
	output lpg_pkg::pixel_t   pix
);

	lpg_pkg::line_desc_t         front_desc;
	lpg_pkg::desc_flow_t         q_rd;
	lpg_pkg::back_status_t       back_status;
	logic                        q_full;
	logic                        q_push;
	logic [lpg_pkg::QCNT_W-1:0]  q_count;

	assign seg_ready = !q_full;
	assign q_push    = seg_valid && seg_ready;

	// Classify segments
	lpg_front u_front (
		.seg  (seg),
		.desc (front_desc)
	);

	// Buffer descriptors between classifier and stepper
	lpg_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_desc (front_desc),
		.full    (q_full),
		.pop     (back_status.pop),
		.rd      (q_rd),
		.count   (q_count)
	);

	// Step out pixels
	lpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (q_rd),
		.status    (back_status),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	// Queue occupancy never exceeds its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= lpg_pkg::QCNT_W'(lpg_pkg::QUEUE_DEPTH))
		else $error("descriptor queue overflow");

	// The stepper only pops an occupied queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.pop |-> q_count != '0)
		else $error("pop from empty descriptor queue");

	// A pixel that is not the last one leaves the stepper still on its line
	a_line_continues: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !pix.last_pixel |-> back_status.active)
		else $error("line ended before its last pixel");

	// The stepper is never active without having loaded a line
	a_active_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(back_status.active) |-> $past(back_status.pop))
		else $error("stepper started without a descriptor");

endmodule
